// File: rtl/core/vector_distance_engine_unit_assert.svh
// assertion macros for the vector distance engine
`ifndef VECTOR_DISTANCE_ENGINE_UNIT_ASSERT_SVH
`define VECTOR_DISTANCE_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define VDE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector distance engine: same-cycle check failed");

// next-cycle implication, held off during reset
`define VDE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vector distance engine: next-cycle check failed");

`endif

// File: rtl/core/vde_pkg.sv
// shared types, constants and helpers of the vector distance engine
package vde_pkg;

    localparam int ELEM_W    = 16;
    localparam int DIFF_W    = ELEM_W + 1;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int DOT_W     = 44;
    localparam int NORM_W    = 43;
    localparam int DSQ_W     = 45;
    localparam int ABS_W     = 29;
    localparam int DIST_W    = 32;
    localparam int WIDE_W    = 36;
    localparam int METRIC_W  = 2;
    localparam int ROOT_IN_W = 64;
    localparam int ROOT_W    = 32;
    localparam int REM_W     = 34;
    localparam int ROOT_CNT_W = 5;
    localparam int E_W       = 6;
    localparam int E_MAX     = 60;
    localparam int NORM_TOP  = 4;
    localparam int SQ_W      = 31;
    localparam int QUO_W     = 34;
    localparam int DIV_CNT_W = 7;
    localparam int K_BIAS    = 15;
    localparam int PRE_SHIFT = 12;
    localparam int EUC_SHIFT = 4;
    localparam int MAN_SHIFT = 2;

    localparam logic signed [WIDE_W-1:0] ONE_Q16_W = 36'sd65536;
    localparam logic signed [DIST_W-1:0] ONE_Q16   = 32'sd65536;
    localparam logic signed [DIST_W-1:0] DIST_MAX  = 32'sh7fff_ffff;
    localparam logic signed [DIST_W-1:0] DIST_MIN  = 32'sh8000_0000;

    typedef enum logic [METRIC_W-1:0] {
        M_EUCLID    = 2'd0,
        M_PRENORM   = 2'd1,
        M_MANHATTAN = 2'd2,
        M_COSINE    = 2'd3
    } t_metric;

    typedef enum logic [1:0] {
        SRC_DIFF   = 2'd0,
        SRC_NORM_A = 2'd1,
        SRC_NORM_B = 2'd2
    } t_root_src;

    typedef struct packed {
        logic signed [ELEM_W-1:0] a_elem;
        logic signed [ELEM_W-1:0] b_elem;
        logic                     has_pair;
        logic                     last;
    } t_vde_in;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic                     degenerate;
    } t_vde_out;

    typedef struct packed {
        logic      take;
        logic      root_start;
        t_root_src root_src;
        logic      root_norm;
        logic      cap_sa;
        logic      cap_sb;
        logic      mul;
        logic      div_start;
        logic      out_load;
    } t_vde_cmd;

    typedef struct packed {
        t_metric metric;
        logic    empty;
        logic    zero_norm;
        logic    root_busy;
        logic    root_done;
        logic    div_busy;
        logic    div_done;
        logic    out_busy;
    } t_vde_sts;

    function automatic logic signed [DIST_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [DIST_W-1:0] res;
        if ((&v[WIDE_W-1:DIST_W-1]) || !(|v[WIDE_W-1:DIST_W-1])) begin
            res = v[DIST_W-1:0];
        end else if (v[WIDE_W-1]) begin
            res = DIST_MIN;
        end else begin
            res = DIST_MAX;
        end
        return res;
    endfunction

endpackage

// File: rtl/core/vde_sqrt.sv
// iterative integer square root with optional even-power normalisation
module vde_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_norm,
    input  logic [vde_pkg::ROOT_IN_W-1:0]  i_rad,
    output logic                           o_busy,
    output logic                           o_done,
    output logic [vde_pkg::ROOT_W-1:0]     o_root,
    output logic [vde_pkg::E_W-1:0]        o_e
);
    import vde_pkg::*;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic                  r_norm, n_norm;
    logic [ROOT_IN_W-1:0]  r_x, n_x;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic [ROOT_W-1:0]     r_root, n_root;
    logic [ROOT_CNT_W-1:0] r_cnt, n_cnt;
    logic [E_W-1:0]        r_e, n_e;
    logic [REM_W+1:0]      w_rem_t;
    logic [REM_W+1:0]      w_trial;

    assign w_rem_t = {r_rem, r_x[ROOT_IN_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_norm = r_norm;
        n_x    = r_x;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_e    = r_e;
        if (i_start) begin
            n_busy = 1'b1;
            n_norm = i_norm;
            n_x    = i_rad;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = '0;
            n_e    = '0;
        end else if (r_busy && r_norm) begin
            // bring the leading bits into the top nibble, two at a time
            if (!(|r_x[ROOT_IN_W-1 -: NORM_TOP]) && (r_e != E_W'(E_MAX))) begin
                n_x = r_x << 2;
                n_e = r_e + E_W'(2);
            end else begin
                n_norm = 1'b0;
            end
        end else if (r_busy) begin
            n_x = r_x << 2;
            if (w_rem_t >= w_trial) begin
                n_rem  = REM_W'(w_rem_t - w_trial);
                n_root = {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = REM_W'(w_rem_t);
                n_root = {r_root[ROOT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + ROOT_CNT_W'(1);
            if (&r_cnt) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_norm <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_norm <= n_norm;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_e    <= n_e;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root;
    assign o_e    = r_e;

endmodule

// File: rtl/core/vde_div.sv
// bit-serial restoring divider for (dividend * 2^k) / divisor with overflow flag
module vde_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [vde_pkg::DOT_W-1:0]     i_dend,
    input  logic [vde_pkg::E_W-1:0]       i_k,
    input  logic [vde_pkg::SQ_W-1:0]      i_dsor,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [vde_pkg::QUO_W-1:0]     o_quot,
    output logic                          o_ovf
);
    import vde_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DOT_W-1:0]     r_dsh, n_dsh;
    logic [SQ_W-1:0]      r_dsor, n_dsor;
    logic [SQ_W-1:0]      r_rem, n_rem;
    logic [QUO_W-1:0]     r_q, n_q;
    logic                 r_ovf, n_ovf;
    logic [SQ_W:0]        w_rem_t;
    logic                 w_qb;

    // dividend bits first, then k zero bits
    assign w_rem_t = {r_rem, r_dsh[DOT_W-1]};
    assign w_qb    = (w_rem_t >= {1'b0, r_dsor});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dsh  = r_dsh;
        n_dsor = r_dsor;
        n_rem  = r_rem;
        n_q    = r_q;
        n_ovf  = r_ovf;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DOT_W) + DIV_CNT_W'(i_k);
            n_dsh  = i_dend;
            n_dsor = i_dsor;
            n_rem  = '0;
            n_q    = '0;
            n_ovf  = 1'b0;
        end else if (r_busy) begin
            n_dsh = r_dsh << 1;
            n_rem = w_qb ? SQ_W'(w_rem_t - {1'b0, r_dsor}) : SQ_W'(w_rem_t);
            n_q   = {r_q[QUO_W-2:0], w_qb};
            n_ovf = r_ovf | r_q[QUO_W-1];
            n_cnt = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dsh  <= n_dsh;
        r_dsor <= n_dsor;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_ovf  <= n_ovf;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_ovf  = r_ovf;

endmodule

// File: rtl/core/vde_datapath.sv
// accumulators, root and divide units, result formatting and output register
module vde_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vde_pkg::METRIC_W-1:0]    i_cfg_wdata,
    input  vde_pkg::t_vde_in                i_in,
    input  vde_pkg::t_vde_cmd               i_cmd,
    output vde_pkg::t_vde_sts               o_sts,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output vde_pkg::t_vde_out               o_out
);
    import vde_pkg::*;

    t_metric                  r_metric;
    logic                     r_p_vld;
    logic signed [PROD_W-1:0] r_p_ab;
    logic [SQ_W-1:0]          r_p_aa, r_p_bb;
    logic [PROD_W-1:0]        r_p_dd;
    logic [ELEM_W-1:0]        r_p_ad;
    logic signed [DOT_W-1:0]  r_dot, n_dot;
    logic [NORM_W-1:0]        r_na, n_na, r_nb, n_nb;
    logic [DSQ_W-1:0]         r_dsq, n_dsq;
    logic [ABS_W-1:0]         r_abs, n_abs;
    logic                     r_pair;
    logic [SQ_W-1:0]          r_sa, r_sb, r_r;
    logic [E_W-1:0]           r_ea, r_eb;
    logic                     r_out_vld;
    t_vde_out                 r_out, n_out;

    logic signed [ELEM_W-1:0]   w_a, w_b;
    logic signed [PROD_W-1:0]   w_ab, w_aa, w_bb;
    logic signed [DIFF_W-1:0]   w_d;
    logic signed [2*DIFF_W-1:0] w_dd;
    logic [DIFF_W-1:0]          w_ad;
    logic [DOT_W:0]             w_dot_s;
    logic [NORM_W:0]            w_na_s, w_nb_s;
    logic [DSQ_W:0]             w_dsq_s;
    logic [ABS_W:0]             w_abs_s;
    logic                       w_zero_norm;
    logic [ROOT_IN_W-1:0]       w_rad;
    logic [ROOT_W-1:0]          w_root;
    logic [E_W-1:0]             w_e;
    logic                       w_root_busy, w_root_done;
    logic [DOT_W-1:0]           w_dabs;
    logic [E_W:0]               w_esum;
    logic [E_W-1:0]             w_k;
    logic [QUO_W-1:0]           w_quot;
    logic                       w_ovf, w_div_busy, w_div_done;
    logic [2*SQ_W-1:0]          w_prod;
    logic signed [WIDE_W-1:0]   w_pre, w_cos;
    logic                       w_neg;

    // per-pair terms
    assign w_a  = i_in.a_elem;
    assign w_b  = i_in.b_elem;
    assign w_ab = w_a * w_b;
    assign w_aa = w_a * w_a;
    assign w_bb = w_b * w_b;
    assign w_d  = $signed({w_a[ELEM_W-1], w_a}) - $signed({w_b[ELEM_W-1], w_b});
    assign w_dd = w_d * w_d;
    assign w_ad = w_d[DIFF_W-1] ? DIFF_W'(-w_d) : DIFF_W'(w_d);

    // saturating sums
    assign w_dot_s = {r_dot[DOT_W-1], r_dot} + {{(DOT_W+1-PROD_W){r_p_ab[PROD_W-1]}}, r_p_ab};
    assign w_na_s  = {1'b0, r_na} + (NORM_W+1)'(r_p_aa);
    assign w_nb_s  = {1'b0, r_nb} + (NORM_W+1)'(r_p_bb);
    assign w_dsq_s = {1'b0, r_dsq} + (DSQ_W+1)'(r_p_dd);
    assign w_abs_s = {1'b0, r_abs} + (ABS_W+1)'(r_p_ad);

    always_comb begin
        n_dot = r_dot;
        n_na  = r_na;
        n_nb  = r_nb;
        n_dsq = r_dsq;
        n_abs = r_abs;
        if (i_cmd.out_load) begin
            n_dot = '0;
            n_na  = '0;
            n_nb  = '0;
            n_dsq = '0;
            n_abs = '0;
        end else if (r_p_vld) begin
            if (w_dot_s[DOT_W] != w_dot_s[DOT_W-1]) begin
                n_dot = w_dot_s[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
            end else begin
                n_dot = w_dot_s[DOT_W-1:0];
            end
            n_na  = w_na_s[NORM_W] ? '1 : w_na_s[NORM_W-1:0];
            n_nb  = w_nb_s[NORM_W] ? '1 : w_nb_s[NORM_W-1:0];
            n_dsq = w_dsq_s[DSQ_W] ? '1 : w_dsq_s[DSQ_W-1:0];
            n_abs = w_abs_s[ABS_W] ? '1 : w_abs_s[ABS_W-1:0];
        end
    end

    assign w_zero_norm = (r_na == '0) || (r_nb == '0);

    always_comb begin
        case (i_cmd.root_src)
            SRC_DIFF:   w_rad = ROOT_IN_W'({r_dsq, {EUC_SHIFT{1'b0}}});
            SRC_NORM_A: w_rad = ROOT_IN_W'(r_na);
            SRC_NORM_B: w_rad = ROOT_IN_W'(r_nb);
            default:    w_rad = '0;
        endcase
    end

    vde_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.root_start),
        .i_norm  (i_cmd.root_norm),
        .i_rad   (w_rad),
        .o_busy  (w_root_busy),
        .o_done  (w_root_done),
        .o_root  (w_root),
        .o_e     (w_e)
    );

    assign w_dabs = r_dot[DOT_W-1] ? (~r_dot + DOT_W'(1)) : r_dot;
    assign w_esum = {1'b0, r_ea} + {1'b0, r_eb};
    assign w_k    = w_esum[E_W:1] - E_W'(K_BIAS);
    assign w_prod = r_sa * r_sb;

    vde_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_dend  (w_dabs),
        .i_k     (w_k),
        .i_dsor  (r_r),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot),
        .o_ovf   (w_ovf)
    );

    // result formatting
    assign w_neg = r_dot[DOT_W-1];
    assign w_pre = ONE_Q16_W - {{(WIDE_W-DIST_W){r_dot[DOT_W-1]}}, r_dot[DOT_W-1:PRE_SHIFT]};
    assign w_cos = w_neg ? (ONE_Q16_W + $signed({2'b00, w_quot}))
                         : (ONE_Q16_W - $signed({2'b00, w_quot}));

    always_comb begin
        n_out = '0;
        if (!r_pair) begin
            n_out.distance   = (r_metric == M_COSINE) ? ONE_Q16 : '0;
            n_out.degenerate = 1'b1;
        end else begin
            n_out.degenerate = w_zero_norm;
            unique case (r_metric)
                M_EUCLID:    n_out.distance = $signed(w_root);
                M_PRENORM:   n_out.distance = sat32(w_pre);
                M_MANHATTAN: n_out.distance = $signed({1'b0, r_abs, {MAN_SHIFT{1'b0}}});
                M_COSINE: begin
                    if (w_zero_norm) begin
                        n_out.distance = ONE_Q16;
                    end else if (w_ovf) begin
                        n_out.distance = w_neg ? DIST_MAX : DIST_MIN;
                    end else begin
                        n_out.distance = sat32(w_cos);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric  <= M_EUCLID;
            r_p_vld   <= 1'b0;
            r_dot     <= '0;
            r_na      <= '0;
            r_nb      <= '0;
            r_dsq     <= '0;
            r_abs     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_metric <= t_metric'(i_cfg_wdata);
            end
            r_p_vld <= i_cmd.take && i_in.has_pair;
            r_dot   <= n_dot;
            r_na    <= n_na;
            r_nb    <= n_nb;
            r_dsq   <= n_dsq;
            r_abs   <= n_abs;
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_p_ab <= w_ab;
            r_p_aa <= w_aa[SQ_W-1:0];
            r_p_bb <= w_bb[SQ_W-1:0];
            r_p_dd <= w_dd[PROD_W-1:0];
            r_p_ad <= w_ad[ELEM_W-1:0];
        end
        if (i_cmd.take && i_in.last) begin
            r_pair <= i_in.has_pair;
        end
        if (i_cmd.cap_sa) begin
            r_sa <= w_root[SQ_W-1:0];
            r_ea <= w_e;
        end
        if (i_cmd.cap_sb) begin
            r_sb <= w_root[SQ_W-1:0];
            r_eb <= w_e;
        end
        if (i_cmd.mul) begin
            r_r <= w_prod[2*SQ_W-1:SQ_W];
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.metric    = r_metric;
        o_sts.empty     = !r_pair;
        o_sts.zero_norm = w_zero_norm;
        o_sts.root_busy = w_root_busy;
        o_sts.root_done = w_root_done;
        o_sts.div_busy  = w_div_busy;
        o_sts.div_done  = w_div_done;
        o_sts.out_busy  = r_out_vld && i_out_stall;
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

// File: rtl/core/vde_ctrl.sv
// sequencer: accumulation, finishing steps per metric, result hand-off
module vde_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_last,
    input  vde_pkg::t_vde_sts    i_sts,
    output vde_pkg::t_vde_cmd    o_cmd,
    output logic                 o_in_stall
);
    import vde_pkg::*;

    typedef enum logic [9:0] {
        S_ACC   = 10'b00_0000_0001,
        S_DRAIN = 10'b00_0000_0010,
        S_PICK  = 10'b00_0000_0100,
        S_EU    = 10'b00_0000_1000,
        S_RA    = 10'b00_0001_0000,
        S_RB    = 10'b00_0010_0000,
        S_MUL   = 10'b00_0100_0000,
        S_DIVS  = 10'b00_1000_0000,
        S_DIV   = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    t_state   r_state, n_state;
    t_vde_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_ACC: begin
                if (i_in_valid) begin
                    w_cmd.take = 1'b1;
                    if (i_in_last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                n_state = S_PICK;
            end
            S_PICK: begin
                if (i_sts.empty) begin
                    n_state = S_OUT;
                end else begin
                    unique case (i_sts.metric)
                        M_EUCLID: begin
                            w_cmd.root_start = 1'b1;
                            w_cmd.root_src   = SRC_DIFF;
                            n_state          = S_EU;
                        end
                        M_PRENORM, M_MANHATTAN: begin
                            n_state = S_OUT;
                        end
                        M_COSINE: begin
                            if (i_sts.zero_norm) begin
                                n_state = S_OUT;
                            end else begin
                                w_cmd.root_start = 1'b1;
                                w_cmd.root_src   = SRC_NORM_A;
                                w_cmd.root_norm  = 1'b1;
                                n_state          = S_RA;
                            end
                        end
                    endcase
                end
            end
            S_EU: begin
                if (i_sts.root_done) begin
                    n_state = S_OUT;
                end
            end
            S_RA: begin
                if (i_sts.root_done) begin
                    w_cmd.cap_sa     = 1'b1;
                    w_cmd.root_start = 1'b1;
                    w_cmd.root_src   = SRC_NORM_B;
                    w_cmd.root_norm  = 1'b1;
                    n_state          = S_RB;
                end
            end
            S_RB: begin
                if (i_sts.root_done) begin
                    w_cmd.cap_sb = 1'b1;
                    n_state      = S_MUL;
                end
            end
            S_MUL: begin
                w_cmd.mul = 1'b1;
                n_state   = S_DIVS;
            end
            S_DIVS: begin
                w_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = w_cmd;
    assign o_in_stall = (r_state != S_ACC);

endmodule

// File: rtl/core/vector_distance_engine_unit.sv
// vector distance engine: streams element pairs, emits one distance per vector
// input channel: one element pair per transaction (a, b in signed q2.14, has_pair,
//   last); while accumulating the block takes a transaction every cycle
// output channel: one transaction per vector (signed q16.16 distance, degenerate)
// config: a write of the metric register (0 euclidean, 1 prenormalised cosine,
//   2 manhattan, 3 full cosine), only while no vector is in progress
// after the transaction with last set, input stalls until the result is loaded:
//   empty vector, metric 1 or 2, or full cosine with a zero norm: drain, pick, load
//   metric 0: one pass of the 32-step shared square-root unit
//   metric 3: two normalise-and-root passes of that unit and the serial divider
// the output register lets accumulation of the next vector run while a result
//   waits; if the receiver still stalls when the next result is ready, the
//   sequencer holds it and input stays stalled
// reset clears the sums, the metric (to euclidean), the sequencer and the
//   output valid
`include "vector_distance_engine_unit_assert.svh"

module vector_distance_engine_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vde_pkg::METRIC_W-1:0]  i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  vde_pkg::t_vde_in              i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output vde_pkg::t_vde_out             o_out
);
    import vde_pkg::*;

    // command and status between the sequencer and the datapath
    t_vde_cmd w_cmd;
    t_vde_sts w_sts;

    // sequencer: owns the input stall and the order of the finishing steps
    vde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in.last),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // datapath: product stage, saturating sums, root and divide units, output register
    vde_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    // no pair is taken while a root or divide is still running
    `VDE_ASSERT_IMP(a_take_idle, i_clk, i_rst_n, w_cmd.take, !w_sts.root_busy && !w_sts.div_busy)
    // a result is never loaded over one the receiver has not taken
    `VDE_ASSERT_IMP(a_load_free, i_clk, i_rst_n, w_cmd.out_load, !w_sts.out_busy)
    // the last pair closes the input until the result is out
    `VDE_ASSERT_NXT(a_last_stalls, i_clk, i_rst_n, w_cmd.take && i_in.last, o_in_stall)
    // a loaded result shows on the output in the next cycle
    `VDE_ASSERT_NXT(a_load_shows, i_clk, i_rst_n, w_cmd.out_load, o_out_valid)

endmodule
